// ----- rtl/pidl_pkg.sv -----
// ----------------------------------------------------------------------------
// pidl_pkg: shared types and codes for the positional insert/delete list
// Command and status codes, controller states and the command/status structs
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package pidl_pkg;

  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_INS_LAST,
    S_INS_PUT,
    S_DEL_GRAB,
    S_DEL_SHIFT,
    S_DEL_FIN,
    S_READ,
    S_READ_FIN
  } state_t;

  // action applied to the RAM read data in the cycle after the read is issued
  typedef enum logic [2:0] {
    LAG_NONE,
    LAG_UP,
    LAG_DOWN,
    LAG_GRAB,
    LAG_EMIT
  } lag_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_INS,
    PTR_DEL,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef struct packed {
    logic       latch;
    ptr_op_t    ptr_op;
    lag_t       lag;
    logic       put_new;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_got;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       ins_ok;
    logic       del_ok;
    logic       full;
    logic       empty;
    logic       ins_shift;
    logic       del_tail;
    logic       at_pos;
    logic       at_last;
  } sts_t;

endpackage

// ----- rtl/positional_insert_delete_list.sv -----
// ----------------------------------------------------------------------------
// positional_insert_delete_list: ordered list of signed words
// Insert before a 1-based position, delete at a position, or stream all
// entries, over a fixed-capacity entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request (in_cmd, in_position, in_new_value) is taken on a clock edge
//   with start high and busy low. Results come out one per cycle on
//   out_status/out_data/out_last, each marked by a one-cycle out_valid
//   strobe; the receiver must take them as they come.
//   Entries are moved one per cycle through the single RAM read port, so the
//   busy time depends on how many entries move or are listed:
//     range/full/empty errors: answered from the decode step
//     insert: writes the new value at once with nothing to move, else shifts first
//     delete: grabs the deleted entry, then shifts the entries after it down
//     read-all: streams every entry, results coming one per cycle
//   The result of a request is registered and appears in the cycle after the cycle
//   that decides it; a read-all streams its words on back-to-back cycles.
//   Reset empties the list; RAM contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
module positional_insert_delete_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_cmd,
  input  logic [pidl_pkg::POS_W-1:0]         in_position,
  input  logic signed [pidl_pkg::DATA_W-1:0] in_new_value,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic signed [pidl_pkg::DATA_W-1:0] out_data,
  output logic                               out_last
);
  import pidl_pkg::*;

  ctl_t ctl;
  sts_t sts;

  pidl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  pidl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sts          (sts),
    .in_cmd       (in_cmd),
    .in_position  (in_position),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_last     (out_last)
  );

endmodule

// ----- rtl/pidl_ram.sv -----
// ----------------------------------------------------------------------------
// pidl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pidl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/pidl_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidl_ctrl: command sequencer
// Decodes each request and steps the datapath through the shift, grab and
// stream passes, one RAM read per cycle.
// ----------------------------------------------------------------------------
module pidl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  pidl_pkg::sts_t sts,
  output pidl_pkg::ctl_t ctl
);
  import pidl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (sts.cmd)
          CMD_INSERT: begin
            if (sts.ins_ok && !sts.full) begin
              state_nxt = sts.ins_shift ? S_INS_SHIFT : S_INS_PUT;
            end
          end
          CMD_DELETE: begin
            if (sts.del_ok) state_nxt = S_DEL_GRAB;
          end
          CMD_READ: begin
            if (!sts.empty) state_nxt = S_READ;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_INS_SHIFT: begin
        if (sts.at_pos) state_nxt = S_INS_LAST;
      end
      S_INS_LAST:  state_nxt = S_INS_PUT;
      S_INS_PUT:   state_nxt = S_IDLE;
      S_DEL_GRAB:  state_nxt = sts.del_tail ? S_DEL_SHIFT : S_DEL_FIN;
      S_DEL_SHIFT: begin
        if (sts.at_last) state_nxt = S_DEL_FIN;
      end
      S_DEL_FIN:   state_nxt = S_IDLE;
      S_READ: begin
        if (sts.at_last) state_nxt = S_READ_FIN;
      end
      S_READ_FIN:  state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.latch       = 1'b0;
    ctl.ptr_op      = PTR_HOLD;
    ctl.lag         = LAG_NONE;
    ctl.put_new     = 1'b0;
    ctl.cnt_inc     = 1'b0;
    ctl.cnt_dec     = 1'b0;
    ctl.emit        = 1'b0;
    ctl.emit_status = ST_OK;
    ctl.emit_got    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ctl.latch = start;
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_INSERT: begin
            if (!sts.ins_ok) begin
              ctl.emit        = 1'b1;
              ctl.emit_status = ST_RANGE;
            end else if (sts.full) begin
              ctl.emit        = 1'b1;
              ctl.emit_status = ST_FULL;
            end else if (sts.ins_shift) begin
              ctl.ptr_op = PTR_INS;
            end
          end
          CMD_DELETE: begin
            if (!sts.del_ok) begin
              ctl.emit        = 1'b1;
              ctl.emit_status = ST_RANGE;
            end else begin
              ctl.ptr_op = PTR_DEL;
            end
          end
          CMD_READ: begin
            if (sts.empty) begin
              ctl.emit        = 1'b1;
              ctl.emit_status = ST_EMPTY;
            end else begin
              ctl.ptr_op = PTR_ZERO;
            end
          end
          default: ctl.ptr_op = PTR_HOLD;
        endcase
      end
      S_INS_SHIFT: begin
        ctl.lag    = LAG_UP;
        ctl.ptr_op = sts.at_pos ? PTR_HOLD : PTR_DEC;
      end
      S_INS_LAST: begin
        ctl.lag = LAG_NONE;
      end
      S_INS_PUT: begin
        ctl.put_new = 1'b1;
        ctl.cnt_inc = 1'b1;
        ctl.emit    = 1'b1;
      end
      S_DEL_GRAB: begin
        ctl.lag    = LAG_GRAB;
        ctl.ptr_op = sts.del_tail ? PTR_INC : PTR_HOLD;
      end
      S_DEL_SHIFT: begin
        ctl.lag    = LAG_DOWN;
        ctl.ptr_op = sts.at_last ? PTR_HOLD : PTR_INC;
      end
      S_DEL_FIN: begin
        ctl.cnt_dec  = 1'b1;
        ctl.emit     = 1'b1;
        ctl.emit_got = 1'b1;
      end
      S_READ: begin
        ctl.lag    = LAG_EMIT;
        ctl.ptr_op = sts.at_last ? PTR_HOLD : PTR_INC;
      end
      S_READ_FIN: begin
        ctl.lag = LAG_NONE;
      end
      default: ctl.lag = LAG_NONE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- rtl/pidl_dp.sv -----
// ----------------------------------------------------------------------------
// pidl_dp: list datapath
// Entry RAM, entry count, walk pointer, lagged read action and the result
// register.
// ----------------------------------------------------------------------------
module pidl_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pidl_pkg::ctl_t                ctl,
  output pidl_pkg::sts_t                sts,
  input  logic [1:0]                    in_cmd,
  input  logic [pidl_pkg::POS_W-1:0]    in_position,
  input  logic signed [pidl_pkg::DATA_W-1:0] in_new_value,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic signed [pidl_pkg::DATA_W-1:0] out_data,
  output logic                          out_last
);
  import pidl_pkg::*;

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = POS_W + 1;

  logic [1:0]        cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  lag_t              lag_r;
  logic              lag_last_r;
  logic [AW-1:0]     rd_addr_r;
  logic [DATA_W-1:0] got_r;
  logic [DATA_W-1:0] got_now;
  logic [DATA_W-1:0] rd_data;

  logic [CMPW-1:0]   pos_x, cnt_x, pos_m1, cnt_m1;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  assign pos_x  = {1'b0, pos_r};
  assign cnt_x  = CMPW'(count_r);
  assign pos_m1 = pos_x - 1'b1;
  assign cnt_m1 = cnt_x - 1'b1;

  always_comb begin
    sts.cmd       = cmd_r;
    sts.ins_ok    = (pos_x != '0) && (pos_x <= cnt_x + 1'b1);
    sts.del_ok    = (pos_x != '0) && (pos_x <= cnt_x);
    sts.full      = (cnt_x == CMPW'(CAPACITY));
    sts.empty     = (cnt_x == '0);
    sts.ins_shift = (pos_x <= cnt_x);
    sts.del_tail  = (pos_x < cnt_x);
    sts.at_pos    = (ptr_r == pos_m1[AW-1:0]);
    sts.at_last   = (ptr_r == cnt_m1[AW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r <= in_cmd;
      pos_r <= in_position;
      val_r <= in_new_value;
    end
  end

  always_comb begin
    case (ctl.ptr_op)
      PTR_INS:  ptr_nxt = cnt_m1[AW-1:0];
      PTR_DEL:  ptr_nxt = pos_m1[AW-1:0];
      PTR_ZERO: ptr_nxt = '0;
      PTR_INC:  ptr_nxt = ptr_r + 1'b1;
      PTR_DEC:  ptr_nxt = ptr_r - 1'b1;
      default:  ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      lag_r       <= LAG_NONE;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      lag_r       <= ctl.lag;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    rd_addr_r    <= ptr_r;
    lag_last_r   <= sts.at_last;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
    if (lag_r == LAG_GRAB) begin
      got_r <= rd_data;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = rd_addr_r;
    wdata = rd_data;
    if (lag_r == LAG_UP) begin
      we    = 1'b1;
      waddr = rd_addr_r + 1'b1;
    end else if (lag_r == LAG_DOWN) begin
      we    = 1'b1;
      waddr = rd_addr_r - 1'b1;
    end else if (ctl.put_new) begin
      we    = 1'b1;
      waddr = pos_m1[AW-1:0];
      wdata = val_r;
    end
  end

  pidl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_r),
    .rdata (rd_data)
  );

  assign got_now = (lag_r == LAG_GRAB) ? rd_data : got_r;

  always_comb begin
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_data_nxt   = '0;
    out_last_nxt   = 1'b1;
    if (lag_r == LAG_EMIT) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rd_data;
      out_last_nxt  = lag_last_r;
    end else if (ctl.emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ctl.emit_status;
      out_data_nxt   = ctl.emit_got ? got_now : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(count_r) <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(((lag_r == LAG_UP) || (lag_r == LAG_DOWN)) && ctl.put_new))
    else $error("shift write and new-value write in the same cycle");

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !((lag_r == LAG_EMIT) && ctl.emit))
    else $error("two results in the same cycle");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cnt_inc |=> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("count did not advance on insert");

endmodule
